// ===== src/assert_macros.svh =====
// assertion helpers used by the engine top
// each use expects clk and rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain invariant, checked every clock edge out of reset
`define LAGE_ASSERT(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// same-cycle implication
`define LAGE_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LAGE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/lage_pkg.sv =====
// ----------------------------------------------------------------------------
// lage_pkg
// shared widths, codes and rule constants of the life generation engine
// ----------------------------------------------------------------------------
package lage_pkg;

    localparam int OP_W      = 2;
    localparam int IDX_W     = 6;
    localparam int LIMIT_W   = 10;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 1;
    localparam int CNT_W     = 4;

    typedef logic [OP_W-1:0]      op_t;
    typedef logic [IDX_W-1:0]     idx_t;
    typedef logic [LIMIT_W-1:0]   limit_t;
    typedef logic [CFG_W-1:0]     cfg_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    typedef logic [CNT_W-1:0]     cnt_t;

    // command codes
    localparam op_t OP_WRITE = 2'd0;
    localparam op_t OP_READ  = 2'd1;
    localparam op_t OP_RUN   = 2'd2;

    // register indexes
    localparam cfg_idx_t REG_ROWS = 1'b0;
    localparam cfg_idx_t REG_COLS = 1'b1;

    localparam cfg_t CFG_RESET = 7'd64;

    // rule b3/s23
    localparam cnt_t BIRTH_CNT   = 4'd3;
    localparam cnt_t SURVIVE_CNT = 4'd2;

endpackage

// ===== src/lage_if.sv =====
// ----------------------------------------------------------------------------
// lage_cmd_if / lage_rsp_if
// valid/ready channels carrying commands into and results out of the engine
// ----------------------------------------------------------------------------
interface lage_cmd_if;
    logic            valid;
    logic            ready;
    lage_pkg::op_t    op;
    lage_pkg::idx_t   row_index;
    lage_pkg::idx_t   col_index;
    logic            cell_value;
    lage_pkg::limit_t generation_limit;

    modport source (output valid, output op, output row_index, output col_index,
                    output cell_value, output generation_limit, input ready);
    modport sink   (input valid, input op, input row_index, input col_index,
                    input cell_value, input generation_limit, output ready);
endinterface

interface lage_rsp_if;
    logic            valid;
    logic            ready;
    logic            cell_out;
    lage_pkg::limit_t generations_done;
    logic            grid_changed;

    modport source (output valid, output cell_out, output generations_done,
                    output grid_changed, input ready);
    modport sink   (input valid, input cell_out, input generations_done,
                    input grid_changed, output ready);
endinterface

// ===== src/lage_ram.sv =====
// ----------------------------------------------------------------------------
// lage_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module lage_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/life_automaton_generation_engine_top.sv =====
// ----------------------------------------------------------------------------
// life_automaton_generation_engine_top
// bounded b3/s23 life grid held one row per ram word, with cell access and
// multi-generation runs that stop at the generation limit or at the first still generation
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake           | payload
//  ---------+-----+---------------------+---------------------------------------
//  cmd      | in  | valid / ready       | op, row_index, col_index, cell_value,
//           |     |                     | generation_limit
//  rsp      | out | valid / ready       | cell_out, generations_done, grid_changed
//  cfg      | in  | cfg_we, no stall    | cfg_index, cfg_data
//
//  write and read commands pass ST_ACCESS and then ST_FINISH on the way to the
//  result register, skipping ST_ACCESS when the cell lies outside the region;
//  cmd.ready returns as the result register is loaded
//  each generation of a run refills the row window in ST_PRIME and ST_LOAD,
//  then sweeps the ram one row per cycle in ST_GEN (one read, one write port)
//  after reset the grid ram is cleared one row per cycle, every row of it,
//  while cmd.ready stays low
//  the result register lets the next command transfer while a result waits;
//  a finished command holds until the result register is free
//
`include "assert_macros.svh"

module life_automaton_generation_engine_top #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    lage_cmd_if.sink             cmd,
    lage_rsp_if.source           rsp,
    input  logic                 cfg_we,
    input  lage_pkg::cfg_idx_t   cfg_index,
    input  lage_pkg::cfg_t       cfg_data
);

    localparam int ROW_W = $clog2(MAX_ROWS);
    localparam int COL_W = $clog2(MAX_COLS);
    localparam int NR_W  = $clog2(MAX_ROWS + 1);
    localparam int NC_W  = $clog2(MAX_COLS + 1);
    localparam int CMP_A = (NR_W > NC_W) ? NR_W : NC_W;
    localparam int CMP_W = (CMP_A > lage_pkg::CFG_W) ? CMP_A : lage_pkg::CFG_W;

    // state codes
    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_ACCESS = 3'd2;
    localparam logic [2:0] ST_PRIME  = 3'd3;
    localparam logic [2:0] ST_LOAD   = 3'd4;
    localparam logic [2:0] ST_GEN    = 3'd5;
    localparam logic [2:0] ST_FINISH = 3'd6;

    // control registers
    logic [2:0]        state_reg, state_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic              out_valid_reg, out_valid_next;
    lage_pkg::cfg_t    rows_reg, rows_next;
    lage_pkg::cfg_t    cols_reg, cols_next;

    // payload registers
    lage_pkg::op_t     op_reg, op_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic              val_reg, val_next;
    lage_pkg::limit_t  limit_reg, limit_next;
    logic [NR_W-1:0]   nr_reg, nr_next;
    logic [NC_W-1:0]   nc_reg, nc_next;
    logic [MAX_COLS-1:0] above_reg, above_next;
    logic [MAX_COLS-1:0] cur_reg, cur_next;
    lage_pkg::limit_t  gen_cnt_reg, gen_cnt_next;
    logic              chg_reg, chg_next;
    logic              res_cell_reg, res_cell_next;
    logic              out_cell_reg, out_cell_next;
    lage_pkg::limit_t  out_gen_reg, out_gen_next;
    logic              out_chg_reg, out_chg_next;

    // ram port
    logic                mem_we;
    logic [ROW_W-1:0]    mem_waddr;
    logic [MAX_COLS-1:0] mem_wdata;
    logic                mem_re;
    logic [ROW_W-1:0]    mem_raddr;
    logic [MAX_COLS-1:0] mem_rdata;

    // clamped region size and address check
    logic [NR_W-1:0]   nr_cfg;
    logic [NC_W-1:0]   nc_cfg;
    logic              in_range;
    logic              cmd_xfer;

    // row window datapath
    logic [NR_W-1:0]     row_p1;
    logic [NR_W-1:0]     row_p2;
    logic                last_row;
    logic [MAX_COLS-1:0] col_mask;
    logic [MAX_COLS-1:0] win_a, win_m, win_b;
    logic [MAX_COLS-1:0] new_row;
    lage_pkg::cnt_t      nb_cnt [MAX_COLS];
    logic                row_diff;
    logic [MAX_COLS-1:0] acc_row;

    lage_ram #(
        .WIDTH (MAX_COLS),
        .DEPTH (MAX_ROWS)
    ) u_grid_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // region size: zero acts as one, oversize acts as the maximum
    always_comb
    begin
        if (rows_reg == '0)
        begin
            nr_cfg = NR_W'(1);
        end
        else if (CMP_W'(rows_reg) > CMP_W'(MAX_ROWS))
        begin
            nr_cfg = NR_W'(MAX_ROWS);
        end
        else
        begin
            nr_cfg = NR_W'(rows_reg);
        end
        if (cols_reg == '0)
        begin
            nc_cfg = NC_W'(1);
        end
        else if (CMP_W'(cols_reg) > CMP_W'(MAX_COLS))
        begin
            nc_cfg = NC_W'(MAX_COLS);
        end
        else
        begin
            nc_cfg = NC_W'(cols_reg);
        end
    end

    assign in_range = (CMP_W'(cmd.row_index) < CMP_W'(nr_cfg))
                   && (CMP_W'(cmd.col_index) < CMP_W'(nc_cfg));
    assign cmd.ready = (state_reg == ST_IDLE);
    assign cmd_xfer  = cmd.valid && cmd.ready;

    // position of the window: row_reg is the row being rewritten
    assign row_p1   = NR_W'(row_reg) + NR_W'(1);
    assign row_p2   = row_p1 + NR_W'(1);
    assign last_row = (row_p1 == nr_reg);

    // cells outside the simulated columns read as dead neighbours
    always_comb
    begin
        for (int c = 0; c < MAX_COLS; c++)
        begin
            col_mask[c] = (c < int'(nc_reg));
        end
    end

    assign win_a = above_reg & col_mask;
    assign win_m = cur_reg & col_mask;
    assign win_b = last_row ? '0 : (mem_rdata & col_mask);

    // per-column neighbour count and rule, one lane per column
    always_comb
    begin
        for (int c = 0; c < MAX_COLS; c++)
        begin
            nb_cnt[c] = lage_pkg::cnt_t'(win_a[c]) + lage_pkg::cnt_t'(win_b[c]);
            if (c > 0)
            begin
                nb_cnt[c] = nb_cnt[c] + lage_pkg::cnt_t'(win_a[c-1])
                          + lage_pkg::cnt_t'(win_m[c-1]) + lage_pkg::cnt_t'(win_b[c-1]);
            end
            if (c < MAX_COLS - 1)
            begin
                nb_cnt[c] = nb_cnt[c] + lage_pkg::cnt_t'(win_a[c+1])
                          + lage_pkg::cnt_t'(win_m[c+1]) + lage_pkg::cnt_t'(win_b[c+1]);
            end
            if (col_mask[c])
            begin
                new_row[c] = (nb_cnt[c] == lage_pkg::BIRTH_CNT)
                          || (win_m[c] && (nb_cnt[c] == lage_pkg::SURVIVE_CNT));
            end
            else
            begin
                new_row[c] = cur_reg[c];
            end
        end
    end

    assign row_diff = |(new_row ^ cur_reg);

    // single-cell update for a write command
    always_comb
    begin
        acc_row          = mem_rdata;
        acc_row[col_reg] = val_reg;
    end

    // main sequencer
    always_comb
    begin
        state_next     = state_reg;
        row_next       = row_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        rows_next      = rows_reg;
        cols_next      = cols_reg;
        op_next        = op_reg;
        col_next       = col_reg;
        val_next       = val_reg;
        limit_next     = limit_reg;
        nr_next        = nr_reg;
        nc_next        = nc_reg;
        above_next     = above_reg;
        cur_next       = cur_reg;
        gen_cnt_next   = gen_cnt_reg;
        chg_next       = chg_reg;
        res_cell_next  = res_cell_reg;
        out_cell_next  = out_cell_reg;
        out_gen_next   = out_gen_reg;
        out_chg_next   = out_chg_reg;
        mem_we         = 1'b0;
        mem_waddr      = row_reg;
        mem_wdata      = acc_row;
        mem_re         = 1'b0;
        mem_raddr      = ROW_W'(cmd.row_index);

        if (cfg_we)
        begin
            case (cfg_index)
                lage_pkg::REG_ROWS: rows_next = cfg_data;
                lage_pkg::REG_COLS: cols_next = cfg_data;
                default: ;
            endcase
        end

        case (state_reg)
            ST_CLEAR:
            begin
                // sweep zeros through the grid after reset
                mem_we    = 1'b1;
                mem_wdata = '0;
                if (row_reg == ROW_W'(MAX_ROWS - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    row_next = row_reg + ROW_W'(1);
                end
            end
            ST_IDLE:
            begin
                if (cmd_xfer)
                begin
                    op_next       = cmd.op;
                    row_next      = ROW_W'(cmd.row_index);
                    col_next      = COL_W'(cmd.col_index);
                    val_next      = cmd.cell_value;
                    limit_next    = cmd.generation_limit;
                    nr_next       = nr_cfg;
                    nc_next       = nc_cfg;
                    gen_cnt_next  = '0;
                    chg_next      = 1'b0;
                    res_cell_next = 1'b0;
                    state_next    = ST_FINISH;
                    case (cmd.op)
                        lage_pkg::OP_WRITE,
                        lage_pkg::OP_READ:
                        begin
                            if (in_range)
                            begin
                                mem_re     = 1'b1;
                                state_next = ST_ACCESS;
                            end
                        end
                        lage_pkg::OP_RUN:
                        begin
                            if (cmd.generation_limit != '0)
                            begin
                                state_next = ST_PRIME;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_ACCESS:
            begin
                // row word has arrived: pick the bit or write it back modified
                if (op_reg == lage_pkg::OP_WRITE)
                begin
                    mem_we = 1'b1;
                end
                else
                begin
                    res_cell_next = mem_rdata[col_reg];
                end
                state_next = ST_FINISH;
            end
            ST_PRIME:
            begin
                mem_re     = 1'b1;
                mem_raddr  = '0;
                above_next = '0;
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                cur_next   = mem_rdata;
                mem_re     = 1'b1;
                mem_raddr  = ROW_W'(1);
                row_next   = '0;
                chg_next   = 1'b0;
                state_next = ST_GEN;
            end
            ST_GEN:
            begin
                // old rows r-1 and r sit in the window, r+1 comes from the ram
                mem_we     = 1'b1;
                mem_waddr  = row_reg;
                mem_wdata  = new_row;
                above_next = cur_reg;
                cur_next   = mem_rdata;
                mem_re     = 1'b1;
                mem_raddr  = (row_p2 < NR_W'(MAX_ROWS)) ? ROW_W'(row_p2) : '0;
                chg_next   = chg_reg || row_diff;
                if (last_row)
                begin
                    gen_cnt_next = gen_cnt_reg + lage_pkg::limit_t'(1);
                    if (!(chg_reg || row_diff) || (gen_cnt_next == limit_reg))
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_PRIME;
                    end
                end
                else
                begin
                    row_next = row_p1[ROW_W-1:0];
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_cell_next  = res_cell_reg;
                    out_gen_next   = gen_cnt_reg;
                    out_chg_next   = chg_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
            rows_reg      <= lage_pkg::CFG_RESET;
            cols_reg      <= lage_pkg::CFG_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            out_valid_reg <= out_valid_next;
            rows_reg      <= rows_next;
            cols_reg      <= cols_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        col_reg      <= col_next;
        val_reg      <= val_next;
        limit_reg    <= limit_next;
        nr_reg       <= nr_next;
        nc_reg       <= nc_next;
        above_reg    <= above_next;
        cur_reg      <= cur_next;
        gen_cnt_reg  <= gen_cnt_next;
        chg_reg      <= chg_next;
        res_cell_reg <= res_cell_next;
        out_cell_reg <= out_cell_next;
        out_gen_reg  <= out_gen_next;
        out_chg_reg  <= out_chg_next;
    end

    // result register drives the output channel
    assign rsp.valid            = out_valid_reg;
    assign rsp.cell_out         = out_cell_reg;
    assign rsp.generations_done = out_gen_reg;
    assign rsp.grid_changed     = out_chg_reg;

    // read-ahead must never hit the row written back in the same cycle
    `LAGE_ASSERT_IMPL(a_no_rw_clash, mem_we && mem_re, mem_waddr != mem_raddr, "ram read and write collide")
    // a generation is only swept while the limit has not been reached
    `LAGE_ASSERT_IMPL(a_gen_in_limit, state_reg == ST_GEN, gen_cnt_reg < limit_reg, "generation count past limit")
    // a finished command with a free result slot shows its result next cycle
    `LAGE_ASSERT_NEXT(a_finish_loads, (state_reg == ST_FINISH) && !out_valid_reg, out_valid_reg, "result not loaded")
    // end of a sweep either starts another generation or finishes
    `LAGE_ASSERT_NEXT(a_sweep_end, (state_reg == ST_GEN) && last_row, (state_reg == ST_PRIME) || (state_reg == ST_FINISH), "bad state after sweep")

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// life generation engine testbench
// drives cell writes, cell reads, generation runs and unused op codes into
// the engine over the command channel, predicts each result from a private copy
// of the grid and region registers, and compares every transferred result field by field
// ----------------------------------------------------------------------------
module testbench;

    localparam int          GRID_ROWS      = 64;
    localparam int          GRID_COLS      = 64;
    localparam int          RANDOM_PHASES  = 20;
    localparam int          PHASE_ITEMS    = 70;
    localparam int          CALM_PHASES    = 2;
    localparam int          TAIL_CYCLES    = 20;
    // slowest single command: 1023 generations over at most 16 rows, plus the
    // clearing sweep after reset, taken several times
    localparam int unsigned WATCHDOG_LIMIT = 400000;

    // op code with no meaning in the engine, must answer all zero
    localparam lage_pkg::op_t OP_UNUSED = 2'd3;

    typedef struct packed {
        lage_pkg::op_t    op;
        lage_pkg::idx_t   row_index;
        lage_pkg::idx_t   col_index;
        logic             cell_value;
        lage_pkg::limit_t generation_limit;
    } command_t;

    typedef struct packed {
        logic             cell_out;
        lage_pkg::limit_t generations_done;
        logic             grid_changed;
    } result_t;

    localparam int CMD_W = $bits(command_t);

    // grid copy, region registers and the results still owed by the engine
    class life_grid_tracker;
        logic [GRID_COLS-1:0] cells [GRID_ROWS];
        lage_pkg::cfg_t       rows_reg;
        lage_pkg::cfg_t       cols_reg;
        result_t              pending_results [$];
        int unsigned          mismatches;

        function new();
            foreach (cells[r])
                cells[r] = '0;
            rows_reg   = lage_pkg::CFG_RESET;
            cols_reg   = lage_pkg::CFG_RESET;
            mismatches = 0;
        endfunction

        function void set_register(lage_pkg::cfg_idx_t index, lage_pkg::cfg_t data);
            if (index == lage_pkg::REG_ROWS)
                rows_reg = data;
            else
                cols_reg = data;
        endfunction

        // zero acts as one, anything past the grid acts as the grid size
        function int unsigned region(lage_pkg::cfg_t data, int unsigned limit);
            if (data == 0)
                return 1;
            if (data > limit)
                return limit;
            return data;
        endfunction

        // one b3/s23 step over the top-left nr x nc block, row-parallel
        function bit advance_generation(int unsigned nr, int unsigned nc);
            logic [GRID_COLS-1:0] mask;
            logic [GRID_COLS-1:0] above;
            logic [GRID_COLS-1:0] here;
            logic [GRID_COLS-1:0] below;
            logic [GRID_COLS-1:0] fresh;
            logic [GRID_COLS-1:0] next_rows [GRID_ROWS];
            logic [GRID_COLS-1:0] nbr [8];
            int unsigned          live;
            bit                   changed;
            mask    = (nc >= GRID_COLS) ? {GRID_COLS{1'b1}} : ((64'd1 << nc) - 64'd1);
            changed = 1'b0;
            for (int r = 0; r < nr; r++)
            begin
                above  = (r > 0) ? (cells[r-1] & mask) : '0;
                here   = cells[r] & mask;
                below  = (r + 1 < nr) ? (cells[r+1] & mask) : '0;
                nbr[0] = above << 1;
                nbr[1] = above;
                nbr[2] = above >> 1;
                nbr[3] = here << 1;
                nbr[4] = here >> 1;
                nbr[5] = below << 1;
                nbr[6] = below;
                nbr[7] = below >> 1;
                fresh  = '0;
                for (int c = 0; c < nc; c++)
                begin
                    live = 0;
                    for (int k = 0; k < 8; k++)
                        live += nbr[k][c];
                    fresh[c] = (live == lage_pkg::BIRTH_CNT)
                            || (here[c] && live == lage_pkg::SURVIVE_CNT);
                end
                next_rows[r] = fresh;
            end
            for (int r = 0; r < nr; r++)
            begin
                if (((next_rows[r] ^ cells[r]) & mask) != '0)
                    changed = 1'b1;
                cells[r] = (cells[r] & ~mask) | next_rows[r];
            end
            return changed;
        endfunction

        function void note_command(command_t c);
            result_t     want;
            int unsigned nr;
            int unsigned nc;
            bit          inside_region;
            bit          moved;
            nr            = region(rows_reg, GRID_ROWS);
            nc            = region(cols_reg, GRID_COLS);
            inside_region = (c.row_index < nr) && (c.col_index < nc);
            want          = '0;
            case (c.op)
                lage_pkg::OP_WRITE:
                    if (inside_region)
                        cells[c.row_index][c.col_index] = c.cell_value;
                lage_pkg::OP_READ:
                    if (inside_region)
                        want.cell_out = cells[c.row_index][c.col_index];
                lage_pkg::OP_RUN:
                    for (int g = 0; g < c.generation_limit; g++)
                    begin
                        moved                 = advance_generation(nr, nc);
                        want.generations_done = want.generations_done
                                              + lage_pkg::limit_t'(1);
                        want.grid_changed     = moved;
                        if (!moved)
                            break;
                    end
                default: ;
            endcase
            pending_results.push_back(want);
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending_results.size() == 0)
            begin
                $error("result with nothing outstanding: cell_out %0d %s %0d %s %0d",
                       got.cell_out, "generations_done", got.generations_done,
                       "grid_changed", got.grid_changed);
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            if (got.cell_out !== want.cell_out)
            begin
                $error("cell_out: expected %0d, actual %0d", want.cell_out, got.cell_out);
                mismatches++;
            end
            if (got.generations_done !== want.generations_done)
            begin
                $error("generations_done: expected %0d, actual %0d",
                       want.generations_done, got.generations_done);
                mismatches++;
            end
            if (got.grid_changed !== want.grid_changed)
            begin
                $error("grid_changed: expected %0d, actual %0d",
                       want.grid_changed, got.grid_changed);
                mismatches++;
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_we;
    lage_pkg::cfg_idx_t cfg_index;
    lage_pkg::cfg_t     cfg_data;

    lage_cmd_if         cmd_ch ();
    lage_rsp_if         rsp_ch ();

    life_grid_tracker   tracker;
    command_t           seen_command;
    result_t            seen_result;
    int unsigned        idle_cycles = 0;
    // 0 means no idling on that side, else 1 in n per command or per result-loop pass
    int unsigned        cmd_gap_odds;
    int unsigned        rsp_gap_odds;

    life_automaton_generation_engine_top #(
        .MAX_ROWS (GRID_ROWS),
        .MAX_COLS (GRID_COLS)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    // transfer monitor and watchdog, values sampled as they stood at the edge
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                seen_command = '{cmd_ch.op, cmd_ch.row_index, cmd_ch.col_index,
                                 cmd_ch.cell_value, cmd_ch.generation_limit};
                tracker.note_command(seen_command);
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                seen_result = '{rsp_ch.cell_out, rsp_ch.generations_done, rsp_ch.grid_changed};
                tracker.check_result(seen_result);
            end
            if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles <= 0;
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("testbench: FAIL");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // result side: ready held high apart from random stall bursts
    initial
    begin
        rsp_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (rsp_gap_odds != 0 && $urandom_range(1, rsp_gap_odds) == 1)
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
        end
    end

    // writes both region registers, only ever called with no command outstanding
    task automatic set_region(input lage_pkg::cfg_t rows, input lage_pkg::cfg_t cols);
        cfg_we    <= 1'b1;
        cfg_index <= lage_pkg::REG_ROWS;
        cfg_data  <= rows;
        @(posedge clk);
        tracker.set_register(lage_pkg::REG_ROWS, rows);
        cfg_index <= lage_pkg::REG_COLS;
        cfg_data  <= cols;
        @(posedge clk);
        tracker.set_register(lage_pkg::REG_COLS, cols);
        cfg_we    <= 1'b0;
    endtask

    // holds the command until its transfer, after an optional gap
    task automatic send_command(input command_t c);
        if (cmd_gap_odds != 0 && $urandom_range(1, cmd_gap_odds) == 1)
        begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        cmd_ch.valid            <= 1'b1;
        cmd_ch.op               <= c.op;
        cmd_ch.row_index        <= c.row_index;
        cmd_ch.col_index        <= c.col_index;
        cmd_ch.cell_value       <= c.cell_value;
        cmd_ch.generation_limit <= c.generation_limit;
        do @(posedge clk); while (!cmd_ch.ready);
    endtask

    // sender pauses until every owed result has been transferred
    task automatic drain;
        cmd_ch.valid <= 1'b0;
        // wait for a clock edge first so the monitor has noted the last transfer
        @(posedge clk);
        while (tracker.pending_results.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    function automatic command_t make_command(lage_pkg::op_t op, int row, int col, bit data,
                                              int limit);
        command_t c;
        c.op               = op;
        c.row_index        = lage_pkg::idx_t'(row);
        c.col_index        = lage_pkg::idx_t'(col);
        c.cell_value       = data;
        c.generation_limit = lage_pkg::limit_t'(limit);
        return c;
    endfunction

    // mostly small regions so that runs stay short, with the odd big or
    // out-of-range value
    function automatic lage_pkg::cfg_t random_size();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 6)
            return lage_pkg::cfg_t'($urandom_range(1, 12));
        if (pick < 8)
            return lage_pkg::cfg_t'($urandom_range(13, 64));
        if (pick == 8)
            return '0;
        return lage_pkg::cfg_t'($urandom_range(65, 127));
    endfunction

    // seeds and probes land mostly inside the live region; long runs only
    // on short grids
    function automatic command_t random_command(int unsigned nr, int unsigned nc);
        command_t    c;
        int unsigned pick;
        c    = command_t'(CMD_W'($urandom));
        pick = $urandom_range(0, 99);
        if (pick < 55)
            c.op = lage_pkg::OP_WRITE;
        else if (pick < 78)
            c.op = lage_pkg::OP_READ;
        else if (pick < 97)
            c.op = lage_pkg::OP_RUN;
        else
            c.op = OP_UNUSED;
        if ($urandom_range(0, 9) < 8)
        begin
            c.row_index = lage_pkg::idx_t'($urandom_range(0, nr - 1));
            c.col_index = lage_pkg::idx_t'($urandom_range(0, nc - 1));
        end
        if (nr <= 16 && $urandom_range(0, 19) == 0)
            c.generation_limit = lage_pkg::limit_t'($urandom_range(0, 1023));
        else
            c.generation_limit = lage_pkg::limit_t'($urandom_range(0, 12));
        return c;
    endfunction

    initial
    begin
        int unsigned nr;
        int unsigned nc;

        tracker                  = new();
        cmd_gap_odds             = 0;
        rsp_gap_odds             = 0;
        rst_n                   <= 1'b0;
        cfg_we                  <= 1'b0;
        cfg_index               <= lage_pkg::REG_ROWS;
        cfg_data                <= '0;
        cmd_ch.valid            <= 1'b0;
        cmd_ch.op               <= lage_pkg::OP_WRITE;
        cmd_ch.row_index        <= '0;
        cmd_ch.col_index        <= '0;
        cmd_ch.cell_value       <= 1'b0;
        cmd_ch.generation_limit <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // 5 x 6 region: zero-limit run, blinker, writes and reads off the region
        set_region(7'd5, 7'd6);
        send_command(make_command(lage_pkg::OP_RUN, 0, 0, 0, 0));
        send_command(make_command(lage_pkg::OP_READ, 0, 0, 0, 0));
        send_command(make_command(lage_pkg::OP_WRITE, 1, 2, 1, 0));
        send_command(make_command(lage_pkg::OP_WRITE, 2, 2, 1, 0));
        send_command(make_command(lage_pkg::OP_WRITE, 3, 2, 1, 0));
        send_command(make_command(lage_pkg::OP_WRITE, 5, 0, 1, 0));
        send_command(make_command(lage_pkg::OP_WRITE, 0, 6, 1, 0));
        send_command(make_command(lage_pkg::OP_WRITE, 63, 63, 1, 0));
        send_command(make_command(lage_pkg::OP_READ, 63, 63, 0, 0));
        send_command(make_command(lage_pkg::OP_READ, 2, 2, 0, 0));
        // blinker never settles, so the full limit is used
        send_command(make_command(lage_pkg::OP_RUN, 0, 0, 0, 1023));
        send_command(make_command(lage_pkg::OP_READ, 2, 1, 0, 0));
        send_command(make_command(OP_UNUSED, 63, 63, 1, 1023));
        send_command(make_command(lage_pkg::OP_RUN, 0, 0, 0, 1));
        send_command(make_command(lage_pkg::OP_READ, 2, 2, 0, 0));
        drain;

        // zero rows acts as one row, oversized columns act as the full width
        set_region(7'd0, 7'd127);
        send_command(make_command(lage_pkg::OP_WRITE, 0, 63, 1, 0));
        send_command(make_command(lage_pkg::OP_WRITE, 1, 0, 1, 0));
        send_command(make_command(lage_pkg::OP_READ, 0, 63, 0, 0));
        // lone cell dies, then a still generation ends the run
        send_command(make_command(lage_pkg::OP_RUN, 0, 0, 0, 2));
        send_command(make_command(lage_pkg::OP_READ, 0, 63, 0, 0));
        drain;

        // full grid: corner l-shape grows into a still block
        set_region(7'd64, 7'd64);
        send_command(make_command(lage_pkg::OP_WRITE, 63, 63, 1, 0));
        send_command(make_command(lage_pkg::OP_WRITE, 62, 63, 1, 0));
        send_command(make_command(lage_pkg::OP_WRITE, 63, 62, 1, 0));
        send_command(make_command(lage_pkg::OP_RUN, 0, 0, 0, 3));
        send_command(make_command(lage_pkg::OP_READ, 62, 62, 0, 0));
        drain;

        // random phases, each under a fresh region; the last ones run flat out
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            set_region(random_size(), random_size());
            nr = tracker.region(tracker.rows_reg, GRID_ROWS);
            nc = tracker.region(tracker.cols_reg, GRID_COLS);
            if (phase >= RANDOM_PHASES - CALM_PHASES)
            begin
                cmd_gap_odds = 0;
                rsp_gap_odds = 0;
            end
            else
            begin
                cmd_gap_odds = (phase % 3 == 0) ? 0 : ((phase % 3 == 1) ? 3 : 8);
                rsp_gap_odds = (phase % 4 == 2) ? 0 : ((phase % 2 == 0) ? 3 : 6);
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_command(random_command(nr, nc));
            drain;
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.pending_results.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
